### sv/hpd_pkg.sv
// Shared types and constants for the haptic PWM driver.
package hpd_pkg;

	localparam int unsigned LEN_W = 16;
	localparam int unsigned MAG_W = 8;
	localparam int unsigned FUNC_W = 2;
	localparam int unsigned PROD_W = LEN_W + MAG_W;
	localparam int unsigned IDX_W = 2;

	localparam logic [LEN_W-1:0] FULL_DRIVE_TICKS = 16'd60000;
	localparam logic [LEN_W-1:0] PERIOD_RESET = 16'd10000;
	localparam logic [LEN_W-1:0] DMIN_RESET = 16'd2100;
	localparam logic DRIVE_LEVEL_RESET = 1'b1;
	localparam logic DIR_LEVEL_RESET = 1'b1;

	localparam logic [FUNC_W-1:0] FUNC_TICK = 2'd0;
	localparam logic [FUNC_W-1:0] FUNC_ENABLE = 2'd1;
	localparam logic [FUNC_W-1:0] FUNC_DISABLE = 2'd2;
	localparam logic [FUNC_W-1:0] FUNC_SET_MAG = 2'd3;

	localparam logic [IDX_W-1:0] REG_PERIOD_LEN = 2'd0;
	localparam logic [IDX_W-1:0] REG_DUTY_MIN = 2'd1;
	localparam logic [IDX_W-1:0] REG_DRIVE_LEVEL = 2'd2;
	localparam logic [IDX_W-1:0] REG_DIR_LEVEL = 2'd3;

	typedef struct packed {
		logic [LEN_W-1:0] period_len;
		logic [LEN_W-1:0] duty_min;
	} cfg_t;

	typedef struct packed {
		logic [FUNC_W-1:0] func;
		logic [LEN_W-1:0]  active_len;
		logic [LEN_W-1:0]  inactive_len;
	} phase_req_t;

endpackage

### sv/haptic_pwm_driver_unit.sv
// Top level of the haptic PWM driver: configuration, phase timer and pins.
//
// Input beats arrive on s_tvalid/s_tready: s_tuser carries the command
// (tick, enable, disable, set magnitude) and s_tdata the 8-bit magnitude.
// Every input beat yields exactly one output beat on m_tvalid/m_tready that
// reports drive pin, direction pin, power request and timer state after it.
// Registers are written on the cfg channel (index 0 period, 1 duty minimum,
// 2 drive active level, 3 direction active level); cfg_ready is always high.
// The magnitude path is a four-stage pipeline (input, multiply, divide by
// 255, length select) followed by the state and output register. One beat
// is taken every cycle while m_tready is high; the phase timer update is
// done in the state register as each beat is taken, so consecutive beats
// never wait on each other.
// When m_tready is low the output beat holds and the pipeline fills; then
// s_tready drops until the output is taken.
// Reset sets the registers to their defaults, stops the timer, drives both
// pins low (inactive for the default levels), powers down and empties the
// pipeline.
module haptic_pwm_driver_unit (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       s_tvalid,
	output logic                       s_tready,
	input  logic [7:0]                 s_tdata,   // [7:0] magnitude
	input  logic [1:0]                 s_tuser,   // [1:0] func
	output logic                       m_tvalid,
	input  logic                       m_tready,
	output logic [7:0]                 m_tdata,   // [0] drive_pin, [1] direction_pin,
	                                              // [2] power_on, [3] timer_running
	input  logic                       cfg_valid,
	output logic                       cfg_ready,
	input  logic [hpd_pkg::IDX_W-1:0]  cfg_index,
	input  logic [15:0]                cfg_data
);

	hpd_pkg::cfg_t               cfg;
	logic [hpd_pkg::LEN_W-1:0]   period_q;
	logic [hpd_pkg::LEN_W-1:0]   dmin_q;
	logic                        drive_lvl_q;
	logic                        dir_lvl_q;

	logic                        req_valid;
	logic                        req_ready;
	hpd_pkg::phase_req_t         req;
	logic                        take;

	logic                        out_valid_q;
	logic                        in_active_q;
	logic                        counting_q;
	logic [hpd_pkg::LEN_W-1:0]   time_left_q;
	logic [hpd_pkg::LEN_W-1:0]   active_len_q;
	logic [hpd_pkg::LEN_W-1:0]   inactive_len_q;
	logic                        drive_q;
	logic                        dir_q;
	logic                        power_q;

	assign cfg_ready = 1'b1;
	assign cfg = {period_q, dmin_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			period_q <= hpd_pkg::PERIOD_RESET;
			dmin_q <= hpd_pkg::DMIN_RESET;
			drive_lvl_q <= hpd_pkg::DRIVE_LEVEL_RESET;
			dir_lvl_q <= hpd_pkg::DIR_LEVEL_RESET;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				hpd_pkg::REG_PERIOD_LEN: period_q <= cfg_data;
				hpd_pkg::REG_DUTY_MIN: dmin_q <= cfg_data;
				hpd_pkg::REG_DRIVE_LEVEL: drive_lvl_q <= cfg_data[0];
				hpd_pkg::REG_DIR_LEVEL: dir_lvl_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	hpd_duty u_duty (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.in_func   (s_tuser),
		.in_mag    (s_tdata),
		.out_valid (req_valid),
		.out_ready (req_ready),
		.out_req   (req)
	);

	assign req_ready = !out_valid_q || m_tready;
	assign take = req_valid && req_ready;

	assign m_tvalid = out_valid_q;
	assign m_tdata = {4'd0, counting_q, power_q, dir_q, drive_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			in_active_q <= 1'b0;
			counting_q <= 1'b0;
			time_left_q <= '0;
			active_len_q <= '0;
			inactive_len_q <= '0;
			drive_q <= 1'b0;
			dir_q <= 1'b0;
			power_q <= 1'b0;
		end else begin
			if (req_ready) out_valid_q <= req_valid;
			if (take) begin
				unique case (req.func)
					hpd_pkg::FUNC_TICK: begin
						if (counting_q) begin
							if (time_left_q > 16'd1) begin
								time_left_q <= time_left_q - 16'd1;
							end else if (in_active_q) begin
								// End of an active phase: with no off time the drive
								// simply stays on for another active phase.
								counting_q <= 1'b1;
								if (inactive_len_q == '0) begin
									drive_q <= drive_lvl_q;
									time_left_q <= active_len_q;
								end else begin
									drive_q <= !drive_lvl_q;
									in_active_q <= 1'b0;
									time_left_q <= inactive_len_q;
								end
							end else if (active_len_q != '0) begin
								drive_q <= drive_lvl_q;
								in_active_q <= 1'b1;
								counting_q <= 1'b1;
								time_left_q <= active_len_q;
							end else begin
								counting_q <= 1'b0;
								time_left_q <= '0;
							end
						end
					end
					hpd_pkg::FUNC_ENABLE: begin
						active_len_q <= req.active_len;
						inactive_len_q <= req.inactive_len;
						power_q <= 1'b1;
						dir_q <= dir_lvl_q;
						if (req.active_len != '0) begin
							drive_q <= drive_lvl_q;
							in_active_q <= 1'b1;
							counting_q <= 1'b1;
							time_left_q <= req.active_len;
						end else begin
							drive_q <= !drive_lvl_q;
							in_active_q <= 1'b0;
							counting_q <= 1'b0;
							time_left_q <= '0;
						end
					end
					hpd_pkg::FUNC_DISABLE: begin
						counting_q <= 1'b0;
						time_left_q <= '0;
						drive_q <= !drive_lvl_q;
						in_active_q <= 1'b0;
						dir_q <= !dir_lvl_q;
						power_q <= 1'b0;
					end
					hpd_pkg::FUNC_SET_MAG: begin
						active_len_q <= req.active_len;
						inactive_len_q <= req.inactive_len;
					end
					default: ;
				endcase
			end
		end
	end

endmodule

### sv/hpd_duty.sv
// Pipelined magnitude to active/inactive length computation.
module hpd_duty (
	input  logic                        clk,
	input  logic                        arst_n,
	input  hpd_pkg::cfg_t               cfg,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic [hpd_pkg::FUNC_W-1:0]  in_func,
	input  logic [hpd_pkg::MAG_W-1:0]   in_mag,
	output logic                        out_valid,
	input  logic                        out_ready,
	output hpd_pkg::phase_req_t         out_req
);

	logic                        v_s1, v_s2, v_s3, v_s4;
	logic                        rdy1, rdy2, rdy3, rdy4;
	logic [hpd_pkg::FUNC_W-1:0]  func_s1, func_s2, func_s3;
	logic [hpd_pkg::MAG_W-1:0]   mag_s1;
	logic [hpd_pkg::PROD_W-1:0]  prod_s2;
	logic [hpd_pkg::LEN_W-1:0]   quo_s3;
	hpd_pkg::phase_req_t         req_s4;

	logic [hpd_pkg::LEN_W-1:0]   dmin;
	logic [hpd_pkg::LEN_W-1:0]   span;
	logic [hpd_pkg::PROD_W:0]    est_sum;
	logic [hpd_pkg::LEN_W:0]     quo_est;
	logic [hpd_pkg::PROD_W:0]    rem;
	logic [hpd_pkg::LEN_W-1:0]   quo;
	logic [hpd_pkg::LEN_W-1:0]   act;
	logic [hpd_pkg::LEN_W-1:0]   rest;
	logic                        full;
	logic [hpd_pkg::LEN_W-1:0]   total;
	hpd_pkg::phase_req_t         req;

	assign rdy4 = !v_s4 || out_ready;
	assign rdy3 = !v_s3 || rdy4;
	assign rdy2 = !v_s2 || rdy3;
	assign rdy1 = !v_s1 || rdy2;
	assign in_ready = rdy1;

	assign out_valid = v_s4;
	assign out_req = req_s4;

	// The duty floor never exceeds the period.
	assign dmin = (cfg.duty_min < cfg.period_len) ? cfg.duty_min : cfg.period_len;
	assign span = cfg.period_len - dmin;

	// Division by 255: x*(1/256 + 1/65536 + 1/2^24) undershoots by at most one,
	// so a single remainder check finishes the quotient.
	assign est_sum = {1'b0, prod_s2} + {9'd0, prod_s2[hpd_pkg::PROD_W-1:8]}
		+ {17'd0, prod_s2[hpd_pkg::PROD_W-1:16]};
	assign quo_est = est_sum[hpd_pkg::PROD_W:8];
	assign rem = {1'b0, prod_s2} - {quo_est, 8'd0} + {8'd0, quo_est};
	assign quo = quo_est[hpd_pkg::LEN_W-1:0] + {15'd0, (rem >= 25'd255)};

	assign act = quo_s3 + dmin;
	assign rest = cfg.period_len - act;
	assign full = (act == cfg.period_len);
	assign total = (cfg.period_len > hpd_pkg::FULL_DRIVE_TICKS) ? cfg.period_len
		: hpd_pkg::FULL_DRIVE_TICKS;

	always_comb begin
		req.func = func_s3;
		req.active_len = act;
		req.inactive_len = rest;
		if (func_s3 == hpd_pkg::FUNC_ENABLE && full) begin
			req.active_len = total;
			req.inactive_len = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			if (rdy1) v_s1 <= in_valid;
			if (rdy2) v_s2 <= v_s1;
			if (rdy3) v_s3 <= v_s2;
			if (rdy4) v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy1 && in_valid) begin
			func_s1 <= in_func;
			mag_s1 <= in_mag;
		end
		if (rdy2 && v_s1) begin
			func_s2 <= func_s1;
			prod_s2 <= mag_s1 * span;
		end
		if (rdy3 && v_s2) begin
			func_s3 <= func_s2;
			quo_s3 <= quo;
		end
		if (rdy4 && v_s3) begin
			req_s4 <= req;
		end
	end

endmodule

### sv/hpd_checker.sv
// Port-level checks for the haptic PWM driver, bound to the top level.
module hpd_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       s_tready,
	input logic       m_tvalid,
	input logic       m_tready,
	input logic [7:0] m_tdata
);

	// A stalled output beat stays offered.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid)
		else $error("output beat dropped while stalled");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> $stable(m_tdata))
		else $error("output beat changed while stalled");

	// The timer only runs after an enable, so it never runs with power off.
	a_timer_power: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tdata[2] |-> !m_tdata[3])
		else $error("timer running with power off");

	// A ready receiver never throttles the input side.
	a_no_stall: assert property (@(posedge clk) disable iff (!arst_n)
		m_tready |-> s_tready)
		else $error("input stalled with output ready");

endmodule

bind haptic_pwm_driver_unit hpd_checker u_hpd_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);

### verif/testbench.sv
// Self-checking stream testbench for the haptic PWM driver top level.
`timescale 1ns / 1ps

module testbench;

	localparam int NPH = 8;
	localparam int HOLD_LEN = 300;
	localparam int IDLE_LIMIT = 2000;

	typedef struct packed {
		logic [hpd_pkg::FUNC_W-1:0] func;
		logic [hpd_pkg::MAG_W-1:0]  mag;
	} cmd_t;

	// Bit 0 is the drive pin, matching the output beat layout.
	typedef struct packed {
		logic running;
		logic power;
		logic dir;
		logic drive;
	} pins_t;

	logic                      clk = 1'b0;
	logic                      arst_n = 1'b0;
	logic                      s_tvalid = 1'b0;
	logic                      s_tready;
	logic [7:0]                s_tdata = '0;
	logic [1:0]                s_tuser = '0;
	logic                      m_tvalid;
	logic                      m_tready = 1'b0;
	logic [7:0]                m_tdata;
	logic                      cfg_valid = 1'b0;
	logic                      cfg_ready;
	logic [hpd_pkg::IDX_W-1:0] cfg_index = '0;
	logic [15:0]               cfg_data = '0;

	haptic_pwm_driver_unit dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always #4 clk = ~clk;

	// Test plan: one register setting per phase, plus how both sides idle.
	int plan_period[NPH] = '{10000, 8, 1, 0, 65535, 5, 20, 3};
	int plan_dmin[NPH]   = '{2100, 3, 0, 65535, 65535, 0, 7, 2};
	int plan_drv[NPH]    = '{1, 1, 0, 0, 1, 1, 0, 1};
	int plan_dir[NPH]    = '{1, 1, 1, 0, 0, 1, 1, 0};
	int plan_items[NPH]  = '{40, 300, 150, 80, 120, 300, 300, 200};
	int plan_gap[NPH]    = '{0, 1, 1, 0, 1, 1, 1, 0};
	int plan_rdy[NPH]    = '{0, 1, 2, 1, 0, 2, 1, 1};
	int plan_hold[NPH]   = '{0, 0, 0, 0, 1, 0, 1, 0};

	cmd_t  cmd_q[$];
	pins_t pin_q[$];

	int gap_mode = 0;
	int rdy_mode = 0;
	int hold_reqs = 0;
	int fails = 0;

	// Predicted configuration and motor state.
	logic [15:0] cf_period = hpd_pkg::PERIOD_RESET;
	logic [15:0] cf_dmin = hpd_pkg::DMIN_RESET;
	logic        cf_drv_lvl = hpd_pkg::DRIVE_LEVEL_RESET;
	logic        cf_dir_lvl = hpd_pkg::DIR_LEVEL_RESET;
	logic        active_ph = 1'b0;
	logic        counting = 1'b0;
	logic [15:0] time_left = '0;
	logic [15:0] act_len = '0;
	logic [15:0] inact_len = '0;
	logic        drive_pin = 1'b0;
	logic        dir_pin = 1'b0;
	logic        power = 1'b0;

	function automatic int unsigned on_time(input logic [7:0] mag);
		int unsigned lo;
		int unsigned span;
		lo = 32'((cf_dmin < cf_period) ? cf_dmin : cf_period);
		span = 32'(cf_period) - lo;
		return (int'(mag) * span) / 255 + lo;
	endfunction

	task automatic halt_drive();
		counting = 1'b0;
		time_left = '0;
		drive_pin = ~cf_drv_lvl;
		active_ph = 1'b0;
	endtask

	task automatic step_motor(input logic [1:0] fn, input logic [7:0] mag, output pins_t res);
		int unsigned per;
		int unsigned duty;
		case (fn)
			hpd_pkg::FUNC_TICK: begin
				if (counting) begin
					if (time_left <= 16'd1) begin
						counting = 1'b0;
						time_left = '0;
						if (active_ph) begin
							if (inact_len == 0) begin
								drive_pin = cf_drv_lvl;
								counting = 1'b1;
								time_left = act_len;
							end else begin
								drive_pin = ~cf_drv_lvl;
								active_ph = 1'b0;
								counting = 1'b1;
								time_left = inact_len;
							end
						end else if (act_len != 0) begin
							drive_pin = cf_drv_lvl;
							active_ph = 1'b1;
							counting = 1'b1;
							time_left = act_len;
						end
					end else begin
						time_left = time_left - 16'd1;
					end
				end
			end
			hpd_pkg::FUNC_ENABLE: begin
				per = 32'(cf_period);
				duty = on_time(mag);
				// Full duty turns into constant drive with no off phase.
				if (duty == per) begin
					per = (per > 32'(hpd_pkg::FULL_DRIVE_TICKS)) ? per
						: 32'(hpd_pkg::FULL_DRIVE_TICKS);
					duty = per;
				end
				halt_drive();
				act_len = duty[15:0];
				inact_len = 16'(per - duty);
				power = 1'b1;
				dir_pin = cf_dir_lvl;
				if (act_len != 0) begin
					drive_pin = cf_drv_lvl;
					active_ph = 1'b1;
					counting = 1'b1;
					time_left = act_len;
				end
			end
			hpd_pkg::FUNC_DISABLE: begin
				halt_drive();
				dir_pin = ~cf_dir_lvl;
				power = 1'b0;
			end
			default: begin
				duty = on_time(mag);
				act_len = duty[15:0];
				inact_len = 16'(32'(cf_period) - duty);
			end
		endcase
		res.drive = drive_pin;
		res.dir = dir_pin;
		res.power = power;
		res.running = counting;
	endtask

	// Driver: tracks accepted beats through the predictor and feeds the next one.
	cmd_t  next_cmd;
	pins_t pred;
	int    burst_left = 0;
	int    gap_left = 0;

	always @(posedge clk) begin
		if (arst_n) begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					hpd_pkg::REG_PERIOD_LEN:  cf_period = cfg_data;
					hpd_pkg::REG_DUTY_MIN:    cf_dmin = cfg_data;
					hpd_pkg::REG_DRIVE_LEVEL: cf_drv_lvl = cfg_data[0];
					hpd_pkg::REG_DIR_LEVEL:   cf_dir_lvl = cfg_data[0];
					default: ;
				endcase
			end
			if (s_tvalid && s_tready) begin
				step_motor(s_tuser, s_tdata, pred);
				pin_q.push_back(pred);
			end
			if (!s_tvalid || s_tready) begin
				if (gap_left > 0) begin
					gap_left--;
					s_tvalid <= 1'b0;
				end else if (cmd_q.size() > 0) begin
					next_cmd = cmd_q.pop_front();
					s_tvalid <= 1'b1;
					s_tuser <= next_cmd.func;
					s_tdata <= next_cmd.mag;
					if (gap_mode != 0) begin
						if (burst_left <= 1) begin
							burst_left = $urandom_range(1, 16);
							gap_left = $urandom_range(1, 12);
						end else begin
							burst_left--;
						end
					end
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// Monitor: checks output beats and throttles m_tready.
	pins_t want;
	int    hold_left = 0;
	int    hold_seen = 0;
	int    rdy_cnt = 0;

	always @(posedge clk) begin
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				if (pin_q.size() == 0) begin
					$error("output beat 0x%02h with no result pending", m_tdata);
					fails++;
				end else begin
					want = pin_q.pop_front();
					if (m_tdata[0] !== want.drive) begin
						$error("drive_pin: expected %0d, actual %0d", want.drive, m_tdata[0]);
						fails++;
					end
					if (m_tdata[1] !== want.dir) begin
						$error("direction_pin: expected %0d, actual %0d", want.dir, m_tdata[1]);
						fails++;
					end
					if (m_tdata[2] !== want.power) begin
						$error("power_on: expected %0d, actual %0d", want.power, m_tdata[2]);
						fails++;
					end
					if (m_tdata[3] !== want.running) begin
						$error("timer_running: expected %0d, actual %0d", want.running,
							m_tdata[3]);
						fails++;
					end
				end
			end
			rdy_cnt <= (rdy_cnt == 6) ? 0 : rdy_cnt + 1;
			if (hold_left > 0) begin
				hold_left <= hold_left - 1;
				m_tready <= 1'b0;
			end else if (hold_seen != hold_reqs) begin
				hold_seen <= hold_reqs;
				hold_left <= HOLD_LEN;
				m_tready <= 1'b0;
			end else begin
				case (rdy_mode)
					0: m_tready <= 1'b1;
					1: m_tready <= ($urandom_range(0, 9) > 2);
					default: m_tready <= (rdy_cnt > 2);
				endcase
			end
		end
	end

	// Watchdog on cycles without any accepted beat.
	int idle_cycles = 0;

	always @(posedge clk) begin
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("simulation failed");
			$finish;
		end else if ((s_tvalid && s_tready) || (m_tvalid && m_tready) ||
				(cfg_valid && cfg_ready)) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	task automatic add_cmd(input logic [1:0] fn, input logic [7:0] mag);
		cmd_t c;
		c.func = fn;
		c.mag = mag;
		cmd_q.push_back(c);
	endtask

	task automatic wait_drained();
		while (cmd_q.size() != 0 || s_tvalid || pin_q.size() != 0)
			@(negedge clk);
		// Let the pipeline settle before touching registers.
		repeat (8) @(negedge clk);
	endtask

	task automatic write_reg(input logic [hpd_pkg::IDX_W-1:0] idx, input logic [15:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
	endtask

	initial begin
		int roll;
		logic [7:0] mag;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		for (int p = 0; p < NPH; p++) begin
			if (p > 0) begin
				wait_drained();
				@(posedge clk);
				write_reg(hpd_pkg::REG_PERIOD_LEN, 16'(plan_period[p]));
				write_reg(hpd_pkg::REG_DUTY_MIN, 16'(plan_dmin[p]));
				write_reg(hpd_pkg::REG_DRIVE_LEVEL, 16'(plan_drv[p]));
				write_reg(hpd_pkg::REG_DIR_LEVEL, 16'(plan_dir[p]));
				cfg_valid <= 1'b0;
				@(negedge clk);
			end
			gap_mode = plan_gap[p];
			rdy_mode = plan_rdy[p];
			if (p == 0) begin
				// Reset settings: full scale, live change, disable and idle commands.
				add_cmd(hpd_pkg::FUNC_ENABLE, 8'd255);
				add_cmd(hpd_pkg::FUNC_TICK, 8'd0);
				add_cmd(hpd_pkg::FUNC_SET_MAG, 8'd0);
				add_cmd(hpd_pkg::FUNC_TICK, 8'd255);
				add_cmd(hpd_pkg::FUNC_DISABLE, 8'd0);
				add_cmd(hpd_pkg::FUNC_SET_MAG, 8'd128);
				add_cmd(hpd_pkg::FUNC_ENABLE, 8'd0);
				add_cmd(hpd_pkg::FUNC_TICK, 8'd0);
				add_cmd(hpd_pkg::FUNC_DISABLE, 8'd255);
			end else if (p == 1) begin
				// Short period: walk through both phase ends, then drop the off phase.
				add_cmd(hpd_pkg::FUNC_ENABLE, 8'd0);
				for (int i = 0; i < 9; i++)
					add_cmd(hpd_pkg::FUNC_TICK, 8'd0);
				add_cmd(hpd_pkg::FUNC_SET_MAG, 8'd255);
				for (int i = 0; i < 4; i++)
					add_cmd(hpd_pkg::FUNC_TICK, 8'd0);
				add_cmd(hpd_pkg::FUNC_DISABLE, 8'd0);
			end
			for (int i = 0; i < plan_items[p]; i++) begin
				if (plan_hold[p] != 0 && i == plan_items[p] / 2)
					hold_reqs++;
				roll = $urandom_range(0, 99);
				if ($urandom_range(0, 7) == 0)
					mag = ($urandom_range(0, 1) == 1) ? 8'd255 : 8'd0;
				else
					mag = 8'($urandom_range(0, 255));
				if (roll < 65)
					add_cmd(hpd_pkg::FUNC_TICK, mag);
				else if (roll < 78)
					add_cmd(hpd_pkg::FUNC_SET_MAG, mag);
				else if (roll < 91)
					add_cmd(hpd_pkg::FUNC_ENABLE, mag);
				else
					add_cmd(hpd_pkg::FUNC_DISABLE, mag);
			end
		end
		wait_drained();
		repeat (10) @(posedge clk);
		if (fails == 0 && pin_q.size() == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule
